// File: rtl/msrh_pkg.sv
// Shared types and constants for the motor speed ramp and H-bridge controller.
package msrh_pkg;

  // Command codes carried by the operation field.
  typedef enum logic [2:0] {
    OP_TICK           = 3'd0,
    OP_SET_DIRECTION  = 3'd1,
    OP_SET_SPEED      = 3'd2,
    OP_MOVE           = 3'd3,
    OP_RAMP_TO_SPEED  = 3'd4,
    OP_MOVE_WITH_RAMP = 3'd5,
    OP_STOP           = 3'd6,
    OP_EMERGENCY_STOP = 3'd7
  } op_e;

  // Stored direction codes.
  localparam logic [1:0] DIR_STOP     = 2'd0;
  localparam logic [1:0] DIR_FORWARD  = 2'd1;
  localparam logic [1:0] DIR_BACKWARD = 2'd2;

  // Field and register widths.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned SPEED_W = 11;
  localparam int unsigned LIM_W   = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DUTY_FLOOR = 3'd0;
  localparam logic [2:0] REG_DUTY_CEIL  = 3'd1;
  localparam logic [2:0] REG_SLEW_STEP  = 3'd2;
  localparam logic [2:0] REG_SLEW_WAIT  = 3'd3;
  localparam logic [2:0] REG_HALT_DUTY  = 3'd4;

  // Register values after reset.
  localparam logic [LIM_W-1:0]   RST_DUTY_FLOOR = 8'd0;
  localparam logic [LIM_W-1:0]   RST_DUTY_CEIL  = 8'd255;
  localparam logic [LIM_W-1:0]   RST_SLEW_STEP  = 8'd5;
  localparam logic [DELAY_W-1:0] RST_SLEW_WAIT  = 16'd20;
  localparam logic [LIM_W-1:0]   RST_HALT_DUTY  = 8'd0;

endpackage

// File: rtl/motor_speed_ramp_hbridge.sv
// Motor speed ramp controller with slew limiting and H-bridge direction outputs.
//
// Each request (tick or command) is taken into an input register and, once the
// result register is free or draining, applied to the motor state through one
// clamp and one compare-and-add stage, which also loads the result register. The
// block sustains one request per clock cycle while the result side does not
// stall; a request passes through the input register and then the result
// register before its result is offered. The rate is set by the state update
// loop through the motor state registers. An input register and a result
// register decouple the two sides, so one more request is taken while a result
// waits. Configuration is written through an APB-style port with registers at
// byte addresses 0 (lowest duty), 4 (highest duty), 8 (duty change per ramp
// step), 12 (ticks between ramp steps) and 16 (duty set by the stop command).
module motor_speed_ramp_hbridge #(
  parameter int unsigned DUTY_BITS       = 8,
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [msrh_pkg::OP_W-1:0]           operation_i,
  input  logic [msrh_pkg::DIR_W-1:0]          direction_i,
  input  logic signed [msrh_pkg::SPEED_W-1:0] speed_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [DUTY_BITS-1:0]                duty_o,
  output logic                                bridge_in1_o,
  output logic                                bridge_in2_o,
  output logic [msrh_pkg::DIR_W-1:0]          direction_now_o,
  output logic                                ramp_active_o,
  output logic                                moving_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [msrh_pkg::ADDR_W-1:0]         paddr,
  input  logic [msrh_pkg::DATA_W-1:0]         pwdata,
  output logic [msrh_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned SAT_W = (DUTY_BITS > msrh_pkg::LIM_W) ? DUTY_BITS : msrh_pkg::LIM_W;
  localparam int unsigned SUM_W = SAT_W + 1;
  localparam int unsigned CNT_W = (TICK_COUNT_BITS > msrh_pkg::DELAY_W) ?
                                  TICK_COUNT_BITS : msrh_pkg::DELAY_W;
  localparam logic [SAT_W-1:0] DUTY_MAX = SAT_W'((64'd1 << DUTY_BITS) - 64'd1);
  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

  // Configuration registers.
  logic [msrh_pkg::LIM_W-1:0]   duty_floor_q, duty_ceil_q, slew_step_q, halt_duty_q;
  logic [msrh_pkg::DELAY_W-1:0] slew_wait_q;
  logic                         cfg_write;

  // Input register.
  logic                                in_valid_q;
  msrh_pkg::op_e                       op_q;
  logic [msrh_pkg::DIR_W-1:0]          dir_in_q;
  logic signed [msrh_pkg::SPEED_W-1:0] speed_q;

  // Motor state.
  logic [DUTY_BITS-1:0]       duty_q, duty_d;
  logic [DUTY_BITS-1:0]       target_q, target_d;
  logic                       ramp_q, ramp_d;
  logic [msrh_pkg::DIR_W-1:0] dir_q, dir_d;
  logic [TICK_COUNT_BITS-1:0] elapsed_q, elapsed_d;

  // Result register.
  logic                       res_valid_q;
  logic [DUTY_BITS-1:0]       res_duty_q;
  logic [msrh_pkg::DIR_W-1:0] res_dir_q;
  logic                       res_ramp_q;

  logic                       advance;
  logic [DUTY_BITS-1:0]       speed_clamped;
  logic [DUTY_BITS-1:0]       stop_clamped;
  logic [msrh_pkg::DIR_W-1:0] dir_req;
  logic [TICK_COUNT_BITS-1:0] elapsed_inc;
  logic                       step_due;
  logic [SUM_W-1:0]           sum_up;
  logic [SUM_W-1:0]           reach_down;

  // Clamp a requested speed to the configured limits and the duty range.
  function automatic logic [DUTY_BITS-1:0] clamp_speed(
    input logic signed [msrh_pkg::SPEED_W-1:0] v,
    input logic [msrh_pkg::LIM_W-1:0]          lo,
    input logic [msrh_pkg::LIM_W-1:0]          hi
  );
    logic signed [msrh_pkg::SPEED_W-1:0] lo_s;
    logic signed [msrh_pkg::SPEED_W-1:0] hi_s;
    logic [msrh_pkg::LIM_W-1:0]          lim;
    logic [SAT_W-1:0]                    wide;
    lo_s = $signed({{(msrh_pkg::SPEED_W - msrh_pkg::LIM_W){1'b0}}, lo});
    hi_s = $signed({{(msrh_pkg::SPEED_W - msrh_pkg::LIM_W){1'b0}}, hi});
    if (v < lo_s) begin
      lim = lo;
    end else if (v > hi_s) begin
      lim = hi;
    end else begin
      lim = v[msrh_pkg::LIM_W-1:0];
    end
    wide = SAT_W'(lim);
    if (wide > DUTY_MAX) begin
      wide = DUTY_MAX;
    end
    return wide[DUTY_BITS-1:0];
  endfunction

  // The configuration port never stalls.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_floor_q <= msrh_pkg::RST_DUTY_FLOOR;
      duty_ceil_q  <= msrh_pkg::RST_DUTY_CEIL;
      slew_step_q  <= msrh_pkg::RST_SLEW_STEP;
      slew_wait_q  <= msrh_pkg::RST_SLEW_WAIT;
      halt_duty_q  <= msrh_pkg::RST_HALT_DUTY;
    end else if (cfg_write) begin
      case (paddr[4:2])
        msrh_pkg::REG_DUTY_FLOOR: duty_floor_q <= pwdata[msrh_pkg::LIM_W-1:0];
        msrh_pkg::REG_DUTY_CEIL:  duty_ceil_q  <= pwdata[msrh_pkg::LIM_W-1:0];
        msrh_pkg::REG_SLEW_STEP:  slew_step_q  <= pwdata[msrh_pkg::LIM_W-1:0];
        msrh_pkg::REG_SLEW_WAIT:  slew_wait_q  <= pwdata[msrh_pkg::DELAY_W-1:0];
        msrh_pkg::REG_HALT_DUTY:  halt_duty_q  <= pwdata[msrh_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[4:2])
      msrh_pkg::REG_DUTY_FLOOR: prdata = msrh_pkg::DATA_W'(duty_floor_q);
      msrh_pkg::REG_DUTY_CEIL:  prdata = msrh_pkg::DATA_W'(duty_ceil_q);
      msrh_pkg::REG_SLEW_STEP:  prdata = msrh_pkg::DATA_W'(slew_step_q);
      msrh_pkg::REG_SLEW_WAIT:  prdata = msrh_pkg::DATA_W'(slew_wait_q);
      msrh_pkg::REG_HALT_DUTY:  prdata = msrh_pkg::DATA_W'(halt_duty_q);
      default:                  prdata = '0;
    endcase
  end

  // A buffered request is applied when the result register is free or draining.
  assign advance     = in_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q     <= msrh_pkg::op_e'(operation_i);
      dir_in_q <= direction_i;
      speed_q  <= speed_i;
    end
  end

  // Operand preparation: clamped speeds, direction decode and tick counting.
  assign speed_clamped = clamp_speed(speed_q, duty_floor_q, duty_ceil_q);
  assign stop_clamped  = clamp_speed($signed({3'b000, halt_duty_q}), duty_floor_q, duty_ceil_q);
  assign dir_req       = (dir_in_q == msrh_pkg::DIR_FORWARD || dir_in_q == msrh_pkg::DIR_BACKWARD)
                         ? dir_in_q : msrh_pkg::DIR_STOP;
  assign elapsed_inc   = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign step_due      = CNT_W'(elapsed_inc) >= CNT_W'(slew_wait_q);
  assign sum_up        = SUM_W'(duty_q) + SUM_W'(slew_step_q);
  assign reach_down    = SUM_W'(target_q) + SUM_W'(slew_step_q);

  // Next motor state for the buffered request.
  always_comb begin
    duty_d    = duty_q;
    target_d  = target_q;
    ramp_d    = ramp_q;
    dir_d     = dir_q;
    elapsed_d = elapsed_q;
    case (op_q)
      msrh_pkg::OP_TICK: begin
        if (ramp_q) begin
          elapsed_d = elapsed_inc;
          if (step_due) begin
            elapsed_d = '0;
            if (duty_q < target_q) begin
              if (sum_up >= SUM_W'(target_q)) begin
                duty_d = target_q;
                ramp_d = 1'b0;
              end else begin
                duty_d = sum_up[DUTY_BITS-1:0];
              end
            end else if (duty_q > target_q) begin
              if (SUM_W'(duty_q) <= reach_down) begin
                duty_d = target_q;
                ramp_d = 1'b0;
              end else begin
                duty_d = duty_q - DUTY_BITS'(slew_step_q);
              end
            end else begin
              ramp_d = 1'b0;
            end
          end
        end
      end
      msrh_pkg::OP_SET_DIRECTION: begin
        dir_d = dir_req;
      end
      msrh_pkg::OP_SET_SPEED: begin
        duty_d = speed_clamped;
        if (speed_clamped == '0) begin
          dir_d = msrh_pkg::DIR_STOP;
        end
      end
      msrh_pkg::OP_MOVE: begin
        duty_d = speed_clamped;
        dir_d  = (speed_clamped == '0) ? msrh_pkg::DIR_STOP : dir_req;
      end
      msrh_pkg::OP_RAMP_TO_SPEED: begin
        target_d  = speed_clamped;
        ramp_d    = 1'b1;
        elapsed_d = '0;
      end
      msrh_pkg::OP_MOVE_WITH_RAMP: begin
        dir_d     = dir_req;
        target_d  = speed_clamped;
        ramp_d    = 1'b1;
        elapsed_d = '0;
      end
      msrh_pkg::OP_STOP: begin
        duty_d   = stop_clamped;
        dir_d    = msrh_pkg::DIR_STOP;
        ramp_d   = 1'b0;
        target_d = '0;
      end
      default: begin
        duty_d   = '0;
        dir_d    = msrh_pkg::DIR_STOP;
        ramp_d   = 1'b0;
        target_d = '0;
      end
    endcase
  end

  // Motor state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= '0;
      target_q  <= '0;
      ramp_q    <= 1'b0;
      dir_q     <= msrh_pkg::DIR_STOP;
      elapsed_q <= '0;
    end else if (advance) begin
      duty_q    <= duty_d;
      target_q  <= target_d;
      ramp_q    <= ramp_d;
      dir_q     <= dir_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Result register holds the state after each request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_duty_q <= duty_d;
      res_dir_q  <= dir_d;
      res_ramp_q <= ramp_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign duty_o          = res_duty_q;
  assign direction_now_o = res_dir_q;
  assign bridge_in1_o    = (res_dir_q == msrh_pkg::DIR_FORWARD);
  assign bridge_in2_o    = (res_dir_q == msrh_pkg::DIR_BACKWARD);
  assign ramp_active_o   = res_ramp_q;
  assign moving_o        = (res_duty_q != '0) && (res_dir_q != msrh_pkg::DIR_STOP);

endmodule

// File: rtl/msrh_checker.sv
// Port-level checks for the motor speed ramp controller, bound to the top level.
module msrh_checker #(
  parameter int unsigned DUTY_BITS = 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [DUTY_BITS-1:0]       duty_o,
  input logic                       bridge_in1_o,
  input logic                       bridge_in2_o,
  input logic [msrh_pkg::DIR_W-1:0] direction_now_o,
  input logic                       moving_o
);

  // A stalled result stays offered with the same duty.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_o))
    else $error("result dropped or changed while stalled");

  // The bridge is never driven both ways at once.
  a_bridge_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(bridge_in1_o && bridge_in2_o))
    else $error("both bridge inputs high");

  // The bridge inputs follow the reported direction.
  a_bridge_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bridge_in1_o == (direction_now_o == msrh_pkg::DIR_FORWARD)) &&
                    (bridge_in2_o == (direction_now_o == msrh_pkg::DIR_BACKWARD)))
    else $error("bridge inputs disagree with direction");

  // Moving means a nonzero duty and a driving direction.
  a_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> moving_o == ((duty_o != '0) && (bridge_in1_o || bridge_in2_o)))
    else $error("moving flag inconsistent with duty and direction");

endmodule

bind motor_speed_ramp_hbridge msrh_checker #(
  .DUTY_BITS(DUTY_BITS)
) u_msrh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .duty_o         (duty_o),
  .bridge_in1_o   (bridge_in1_o),
  .bridge_in2_o   (bridge_in2_o),
  .direction_now_o(direction_now_o),
  .moving_o       (moving_o)
);

// File: test/tb_motor_speed_ramp_hbridge.sv
// Testbench for the motor speed ramp controller: directed and random commands checked against a predictor.
module tb_motor_speed_ramp_hbridge;

  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned DIR_BITS    = msrh_pkg::DIR_W;
  localparam int unsigned SPEED_BITS  = msrh_pkg::SPEED_W;
  localparam int          TICK_SAT    = (1 << TICK_W) - 1;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // The one direction code that has no meaning of its own and acts as stop.
  localparam logic [DIR_BITS-1:0] DIR_UNUSED_CODE = 2'd3;

  // Status that the block reports after each request.
  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic                bridge_in1;
    logic                bridge_in2;
    logic [DIR_BITS-1:0] dir;
    logic                ramp;
    logic                moving;
  } motor_status_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic [msrh_pkg::OP_W-1:0]          operation_i = msrh_pkg::OP_TICK;
  logic [DIR_BITS-1:0]                direction_i = msrh_pkg::DIR_STOP;
  logic signed [SPEED_BITS-1:0]       speed_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [DUTY_W-1:0]                  duty_o;
  logic                               bridge_in1_o;
  logic                               bridge_in2_o;
  logic [DIR_BITS-1:0]                direction_now_o;
  logic                               ramp_active_o;
  logic                               moving_o;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [msrh_pkg::ADDR_W-1:0]        paddr = '0;
  logic [msrh_pkg::DATA_W-1:0]        pwdata = '0;
  logic [msrh_pkg::DATA_W-1:0]        prdata;
  logic                               pready;

  // Predicted motor state and the configuration it runs under.
  int lim_min, lim_max, step_size, step_delay, stop_duty;
  int pwm_duty, goal_duty, ticks_since_step;
  logic ramping;
  logic [DIR_BITS-1:0] cur_dir;

  motor_status_t expected_status_q[$];
  int unsigned   error_count = 0;
  int unsigned   sent_count = 0;
  int unsigned   checked_count = 0;
  int unsigned   cycle_count = 0;
  logic          calm = 1'b0;
  int unsigned   hold_requests = 0;
  int unsigned   hold_served = 0;
  int unsigned   hold_left = 0;

  motor_speed_ramp_hbridge DUT (.*);

  always #4 clk_i = ~clk_i;

  // Speed clamp, lower bound first: with inverted limits only speeds below the lower limit get it.
  function automatic int clamp_to_limits(int v);
    if (v < lim_min) v = lim_min;
    else if (v > lim_max) v = lim_max;
    if (v > (1 << DUTY_W) - 1) v = (1 << DUTY_W) - 1;
    return v;
  endfunction

  function automatic void store_direction(logic [DIR_BITS-1:0] d);
    cur_dir = (d == msrh_pkg::DIR_FORWARD || d == msrh_pkg::DIR_BACKWARD) ? d
              : msrh_pkg::DIR_STOP;
  endfunction

  // A duty of zero set directly always drops the bridge to stop.
  function automatic void store_duty(int s);
    pwm_duty = clamp_to_limits(s);
    if (pwm_duty == 0) cur_dir = msrh_pkg::DIR_STOP;
  endfunction

  function automatic void begin_ramp(int s);
    goal_duty = clamp_to_limits(s);
    ramping = 1'b1;
    ticks_since_step = 0;
  endfunction

  // Applies one request to the predicted state and returns the status it shows.
  function automatic motor_status_t next_motor_status(msrh_pkg::op_e op,
                                                      logic [DIR_BITS-1:0] d, int s);
    motor_status_t st;
    case (op)
      msrh_pkg::OP_TICK: begin
        if (ramping) begin
          if (ticks_since_step < TICK_SAT) ticks_since_step++;
          if (ticks_since_step >= step_delay) begin
            if (pwm_duty < goal_duty) begin
              pwm_duty += step_size;
              if (pwm_duty >= goal_duty) begin
                pwm_duty = goal_duty;
                ramping = 1'b0;
              end
            end else if (pwm_duty > goal_duty) begin
              pwm_duty -= step_size;
              if (pwm_duty <= goal_duty) begin
                pwm_duty = goal_duty;
                ramping = 1'b0;
              end
            end else begin
              ramping = 1'b0;
            end
            ticks_since_step = 0;
          end
        end
      end
      msrh_pkg::OP_SET_DIRECTION: store_direction(d);
      msrh_pkg::OP_SET_SPEED: store_duty(s);
      msrh_pkg::OP_MOVE: begin
        store_direction(d);
        store_duty(s);
      end
      msrh_pkg::OP_RAMP_TO_SPEED: begin_ramp(s);
      msrh_pkg::OP_MOVE_WITH_RAMP: begin
        store_direction(d);
        begin_ramp(s);
      end
      msrh_pkg::OP_STOP: begin
        store_duty(stop_duty);
        cur_dir = msrh_pkg::DIR_STOP;
        ramping = 1'b0;
        goal_duty = 0;
      end
      default: begin
        // Emergency stop cuts the duty regardless of the limits.
        pwm_duty = 0;
        cur_dir = msrh_pkg::DIR_STOP;
        ramping = 1'b0;
        goal_duty = 0;
      end
    endcase
    st.duty       = DUTY_W'(pwm_duty);
    st.bridge_in1 = (cur_dir == msrh_pkg::DIR_FORWARD);
    st.bridge_in2 = (cur_dir == msrh_pkg::DIR_BACKWARD);
    st.dir        = cur_dir;
    st.ramp       = ramping;
    st.moving     = (pwm_duty > 0) && (cur_dir != msrh_pkg::DIR_STOP);
    return st;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Results are checked before new requests are predicted within one edge.
  always @(posedge clk_i) begin : status_checker
    motor_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status_q.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, actual duty %0d", $time, duty_o);
      end else begin
        want = expected_status_q.pop_front();
        checked_count++;
        check_field("duty", want.duty, duty_o);
        check_field("bridge_in1", want.bridge_in1, bridge_in1_o);
        check_field("bridge_in2", want.bridge_in2, bridge_in2_o);
        check_field("direction_now", want.dir, direction_now_o);
        check_field("ramp_active", want.ramp, ramp_active_o);
        check_field("moving", want.moving, moving_o);
      end
    end
    if (rst_ni && in_valid_i && in_ready_o)
      expected_status_q.push_back(next_motor_status(msrh_pkg::op_e'(operation_i),
                                                    direction_i, speed_i));
  end

  // Result side: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 33);
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one request, with a random gap first, and returns at the edge that takes it.
  task automatic send_request(msrh_pkg::op_e op, logic [DIR_BITS-1:0] d, int s);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 33);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    direction_i <= d;
    speed_i     <= SPEED_BITS'(s);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Waits until every expected result is in and the pipeline has settled.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One write and one read-back on the configuration port.
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    logic [msrh_pkg::DATA_W-1:0] wdata;
    wdata = (idx == msrh_pkg::REG_SLEW_WAIT) ? (value & 32'hFFFF) : (value & 32'hFF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      msrh_pkg::REG_DUTY_FLOOR: lim_min = wdata;
      msrh_pkg::REG_DUTY_CEIL:  lim_max = wdata;
      msrh_pkg::REG_SLEW_STEP:  step_size = wdata;
      msrh_pkg::REG_SLEW_WAIT:  step_delay = wdata;
      default:                  stop_duty = wdata;
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata != wdata) begin
      error_count++;
      $display("%0t: read-back of register %0d, expected %0d, actual %0d",
               $time, idx, wdata, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned mn, int unsigned mx, int unsigned stp,
                           int unsigned dly, int unsigned stop_val);
    drain_requests();
    write_reg(msrh_pkg::REG_DUTY_FLOOR, mn);
    write_reg(msrh_pkg::REG_DUTY_CEIL, mx);
    write_reg(msrh_pkg::REG_SLEW_STEP, stp);
    write_reg(msrh_pkg::REG_SLEW_WAIT, dly);
    write_reg(msrh_pkg::REG_HALT_DUTY, stop_val);
  endtask

  // Mostly in-range speeds, some over the whole field, some right at the limits.
  function automatic logic signed [SPEED_BITS-1:0] pick_speed();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return SPEED_BITS'($urandom_range(255));
    if (roll < 75) return SPEED_BITS'($urandom);
    if (roll < 88) return SPEED_BITS'(lim_min - 1 + int'($urandom_range(2)));
    return SPEED_BITS'(lim_max - 1 + int'($urandom_range(2)));
  endfunction

  // A ramp followed by a run of ticks, with stray commands mixed in; otherwise one
  // command of any kind.
  task automatic send_random_burst();
    int unsigned ticks;
    if ($urandom_range(99) < 60) begin
      send_request($urandom_range(1) ? msrh_pkg::OP_MOVE_WITH_RAMP
                                     : msrh_pkg::OP_RAMP_TO_SPEED,
                   DIR_BITS'($urandom_range(3)), pick_speed());
      ticks = $urandom_range(40);
      repeat (ticks) begin
        if ($urandom_range(99) < 8)
          send_request(msrh_pkg::op_e'($urandom_range(7)), DIR_BITS'($urandom_range(3)),
                       pick_speed());
        else
          send_request(msrh_pkg::OP_TICK, DIR_BITS'($urandom_range(3)),
                       SPEED_BITS'($urandom));
      end
    end else begin
      send_request(msrh_pkg::op_e'($urandom_range(7)), DIR_BITS'($urandom_range(3)),
                   pick_speed());
    end
  endtask

  // All but the ramp commands under the reset configuration, the unused direction code included.
  task automatic test_commands_at_reset();
    send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_FORWARD, 0);
    send_request(msrh_pkg::OP_SET_DIRECTION, msrh_pkg::DIR_FORWARD, 0);
    send_request(msrh_pkg::OP_SET_SPEED, msrh_pkg::DIR_STOP, 1023);
    send_request(msrh_pkg::OP_SET_DIRECTION, DIR_UNUSED_CODE, 0);
    send_request(msrh_pkg::OP_MOVE, msrh_pkg::DIR_BACKWARD, -1024);
    send_request(msrh_pkg::OP_MOVE, msrh_pkg::DIR_BACKWARD, 100);
    send_request(msrh_pkg::OP_STOP, msrh_pkg::DIR_FORWARD, 500);
    send_request(msrh_pkg::OP_MOVE, msrh_pkg::DIR_FORWARD, 50);
    send_request(msrh_pkg::OP_EMERGENCY_STOP, msrh_pkg::DIR_FORWARD, 50);
  endtask

  // Clamping, a stop duty above zero, inverted limits and a zero-wide window.
  task automatic test_speed_limits();
    configure(40, 200, 5, 20, 60);
    send_request(msrh_pkg::OP_MOVE, msrh_pkg::DIR_FORWARD, -1);
    send_request(msrh_pkg::OP_SET_SPEED, msrh_pkg::DIR_STOP, 1023);
    send_request(msrh_pkg::OP_STOP, msrh_pkg::DIR_STOP, 0);
    configure(200, 50, 5, 20, 60);
    send_request(msrh_pkg::OP_MOVE, msrh_pkg::DIR_BACKWARD, 100);
    send_request(msrh_pkg::OP_SET_SPEED, msrh_pkg::DIR_STOP, 250);
    configure(0, 0, 5, 20, 0);
    send_request(msrh_pkg::OP_MOVE, msrh_pkg::DIR_FORWARD, 77);
  endtask

  // Ramps up and down, a direct speed during a ramp, a ramp already at its
  // target, a ramp to zero, and the longest delay.
  task automatic test_ramp_cases();
    configure(0, 255, 100, 0, 0);
    send_request(msrh_pkg::OP_MOVE, msrh_pkg::DIR_FORWARD, 30);
    send_request(msrh_pkg::OP_RAMP_TO_SPEED, msrh_pkg::DIR_STOP, 150);
    send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_STOP, 0);
    send_request(msrh_pkg::OP_SET_SPEED, msrh_pkg::DIR_STOP, 20);
    send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_STOP, 0);
    send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_STOP, 0);
    send_request(msrh_pkg::OP_MOVE_WITH_RAMP, msrh_pkg::DIR_BACKWARD, 150);
    send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_STOP, 0);
    send_request(msrh_pkg::OP_RAMP_TO_SPEED, msrh_pkg::DIR_STOP, 0);
    send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_STOP, 0);
    send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_STOP, 0);
    configure(0, 255, 255, 65535, 0);
    send_request(msrh_pkg::OP_MOVE_WITH_RAMP, msrh_pkg::DIR_FORWARD, 255);
    repeat (3) send_request(msrh_pkg::OP_TICK, msrh_pkg::DIR_STOP, 0);
    send_request(msrh_pkg::OP_EMERGENCY_STOP, msrh_pkg::DIR_STOP, 0);
  endtask

  // The result side holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    int unsigned goal;
    configure(0, 255, 3, 1, 0);
    hold_requests <= hold_requests + 1;
    goal = sent_count + 40;
    while (sent_count < goal) send_random_burst();
  endtask

  // Random traffic over several configurations, the extremes first.
  task automatic test_random_traffic();
    int unsigned goal;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: configure(0, 255, 1, 0, 0);
        1: configure(255, 0, 255, 1, 255);
        2: configure($urandom_range(100), $urandom_range(100, 255), $urandom_range(1, 40),
                     $urandom_range(4), $urandom_range(255));
        3: configure($urandom_range(255), $urandom_range(255), $urandom_range(1, 255),
                     $urandom_range(3), $urandom_range(255));
        default: configure($urandom_range(255), $urandom_range(255), $urandom_range(1, 255),
                           $urandom_range(65535), $urandom_range(255));
      endcase
      // One phase runs with no idling on either side.
      calm <= (phase == 3);
      goal = sent_count + 125;
      while (sent_count < goal) send_random_burst();
    end
    calm <= 1'b0;
  endtask

  initial begin
    lim_min          = msrh_pkg::RST_DUTY_FLOOR;
    lim_max          = msrh_pkg::RST_DUTY_CEIL;
    step_size        = msrh_pkg::RST_SLEW_STEP;
    step_delay       = msrh_pkg::RST_SLEW_WAIT;
    stop_duty        = msrh_pkg::RST_HALT_DUTY;
    pwm_duty         = 0;
    goal_duty        = 0;
    ticks_since_step = 0;
    ramping          = 1'b0;
    cur_dir          = msrh_pkg::DIR_STOP;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_commands_at_reset();
    test_speed_limits();
    test_ramp_cases();
    test_output_backpressure();
    test_random_traffic();
    drain_requests();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results under the reset settings and",
             sent_count, checked_count);
    $display("eleven written configurations, with clamping, ramps, stops and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/msrh_pkg.sv
rtl/motor_speed_ramp_hbridge.sv
rtl/msrh_checker.sv
test/tb_motor_speed_ramp_hbridge.sv
